>>> rtl/core/touch_sample_filter_calibrate_assert.svh
// assertion macros used by the touch filter queue rtl
// each expects clk and arst_n in scope
`ifndef TOUCH_SAMPLE_FILTER_CALIBRATE_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_CALIBRATE_ASSERT_SVH

// same-cycle implication
`define TSFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tsfc_pkg.sv
// ----------------------------------------------------------------------------
// tsfc_pkg
// Types, constants and helpers shared by the touch sample filter blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsfc_pkg;

	localparam int SAMPLE_W   = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int PROD_W     = 46;
	localparam int MAP_W      = 48;
	localparam int GRP_DEPTH  = 2;
	localparam int RES_DEPTH  = 2;

	localparam logic [SAMPLE_W-1:0] Y_FULL_SCALE = 13'd4095;
	localparam int ROUND_HALF = 32768;

	localparam logic signed [31:0] X_GAIN_RST   = -32'sd4463;
	localparam logic signed [31:0] X_OFFSET_RST = 32'sd17126832;
	localparam logic signed [31:0] Y_GAIN_RST   = -32'sd5931;
	localparam logic signed [31:0] Y_OFFSET_RST = 32'sd22922772;
	localparam logic [SAMPLE_W-1:0] X_MIN_RST   = 13'd250;
	localparam logic [SAMPLE_W-1:0] Y_MIN_RST   = 13'd100;
	localparam logic [SAMPLE_W-1:0] AGREE_RST   = 13'd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_GAIN,
		REG_X_OFFSET,
		REG_Y_GAIN,
		REG_Y_OFFSET,
		REG_X_MIN,
		REG_Y_MIN,
		REG_AGREE_RANGE
	} tsfc_reg_t;

	typedef struct packed {
		logic [7:0] high_byte;
		logic [7:0] low_byte;
	} tsfc_sample_t;

	typedef struct packed {
		logic        touch_ok;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
	} tsfc_result_t;

	typedef struct packed {
		logic signed [31:0]  x_gain;
		logic signed [31:0]  x_offset;
		logic signed [31:0]  y_gain;
		logic signed [31:0]  y_offset;
		logic [SAMPLE_W-1:0] x_min;
		logic [SAMPLE_W-1:0] y_min;
		logic [SAMPLE_W-1:0] agree_range;
	} tsfc_cfg_t;

	// gain product plus offset, rounded half up, floor shift, clamp to 16 bits
	function automatic logic [15:0] map_axis(input logic signed [PROD_W-1:0] prod,
			input logic signed [31:0] offset);
		logic signed [MAP_W-1:0] v;
		logic signed [MAP_W-17:0] q;
		v = MAP_W'(prod) + MAP_W'(offset) + MAP_W'(ROUND_HALF);
		q = v[MAP_W-1:16];
		if (q < 0) begin
			map_axis = 16'd0;
		end else if (q > 32'sd65535) begin
			map_axis = 16'hffff;
		end else begin
			map_axis = q[15:0];
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/tsfc_fifo.sv
// ----------------------------------------------------------------------------
// tsfc_fifo
// Small register queue with show-ahead read, used for the group and result queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "touch_sample_filter_calibrate_assert.svh"

module tsfc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			next_ptr = '0;
		end else begin
			next_ptr = p + 1'b1;
		end
	endfunction

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	`TSFC_ASSERT_IMP(a_push_not_full, push, !full, "queue written while full")
	`TSFC_ASSERT_IMP(a_pop_not_empty, pop, !empty, "queue read while empty")
	`TSFC_ASSERT_NXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue count did not follow a lone write")

endmodule

`default_nettype wire

>>> rtl/core/tsfc_front.sv
// ----------------------------------------------------------------------------
// tsfc_front
// Forms 13-bit samples from converter byte pairs and collects X/Y groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsfc_front #(
	parameter int SAMPLES_PER_GROUP = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire tsfc_pkg::tsfc_sample_t sample,
	output logic                       full,
	output logic                       grp_push,
	output logic [SAMPLES_PER_GROUP*tsfc_pkg::SAMPLE_W:0] grp_data,
	input  wire logic                  grp_full
);
	import tsfc_pkg::*;

	localparam int N     = SAMPLES_PER_GROUP;
	localparam int POS_W = $clog2(N);

	logic [SAMPLE_W-1:0] grp_q [N];
	logic [POS_W-1:0]    pos_q;
	logic                is_y_q;
	logic [15:0]         raw_c;
	logic [SAMPLE_W-1:0] smp_c;
	logic                last_c;
	logic                accept;

	always_comb begin
		raw_c = {sample.high_byte, sample.low_byte};
		smp_c = raw_c[15:3];
		// full-scale Y reading means the panel is not pressed
		if (is_y_q && smp_c == Y_FULL_SCALE) begin
			smp_c = '0;
		end
	end

	assign last_c   = pos_q == POS_W'(N - 1);
	assign full     = last_c && grp_full;
	assign accept   = push && !full;
	assign grp_push = accept && last_c;

	always_comb begin
		grp_data = '0;
		for (int i = 0; i < N - 1; i++) begin
			grp_data[i*SAMPLE_W +: SAMPLE_W] = grp_q[i];
		end
		grp_data[(N-1)*SAMPLE_W +: SAMPLE_W] = smp_c;
		grp_data[N*SAMPLE_W] = is_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			is_y_q <= 1'b0;
		end else if (accept) begin
			if (last_c) begin
				pos_q  <= '0;
				is_y_q <= !is_y_q;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grp_q[pos_q] <= smp_c;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/tsfc_back.sv
// ----------------------------------------------------------------------------
// tsfc_back
// Trimmed mean of each group, pair checks and calibration mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsfc_back #(
	parameter int SAMPLES_PER_GROUP = 5,
	parameter int DISCARD_EACH_END  = 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [SAMPLES_PER_GROUP*tsfc_pkg::SAMPLE_W:0] grp_data,
	input  wire logic                   grp_empty,
	output logic                        grp_pop,
	input  wire tsfc_pkg::tsfc_cfg_t    cfg,
	output logic                        res_push,
	output tsfc_pkg::tsfc_result_t      res_data,
	input  wire logic                   res_full
);
	import tsfc_pkg::*;

	localparam int N       = SAMPLES_PER_GROUP;
	localparam int IDX_W   = $clog2(N);
	localparam int CNT_W   = $clog2(N + 1);
	localparam int LO_RAW  = DISCARD_EACH_END;
	localparam int HI_RAW  = N - DISCARD_EACH_END;
	localparam bit TRIM_OK = HI_RAW > LO_RAW;
	localparam int LO      = TRIM_OK ? LO_RAW : (N - 1) / 2;
	localparam int HI      = TRIM_OK ? HI_RAW : LO + 1;
	localparam int KEEP    = HI - LO;
	localparam int SUM_W   = SAMPLE_W + $clog2(N + 1);
	localparam int DIV_SH  = SUM_W + 4;
	localparam int RECIP_W = DIV_SH + 1;
	// ceil(2^DIV_SH / KEEP): exact floor division for every sum in range
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << DIV_SH) + KEEP - 1) / KEEP);

	// stage 1: group waiting for the accumulator
	logic [SAMPLE_W-1:0] vals_s1 [N];
	logic                is_y_s1;
	logic                valid_s1;
	logic [CNT_W-1:0]    rank_c [N];
	logic [N-1:0]        keep_c;

	// accumulator
	logic [SAMPLE_W-1:0] acc_vals_q [N];
	logic [N-1:0]        acc_keep_q;
	logic [SUM_W-1:0]    acc_sum_q;
	logic [CNT_W-1:0]    acc_cnt_q;
	logic                acc_busy_q;
	logic                acc_is_y_q;
	logic [SAMPLE_W-1:0] acc_term_c;
	logic                acc_done;
	logic                acc_load;
	logic                s1_load;
	logic                stall;

	// stage 2: reciprocal product
	logic                      valid_s2;
	logic                      is_y_s2;
	logic [SUM_W+RECIP_W-1:0]  prod_s2;

	// pair state
	logic [SAMPLE_W-1:0] held_x_q, first_x_q, first_y_q;
	logic                second_q;
	logic [SAMPLE_W-1:0] mean_c, dx_c, dy_c;
	logic                ok_c, agree_c;
	logic [SAMPLE_W:0]   sum_x_c, sum_y_c;

	// stage 3 and 4
	logic                emit_s3, ok_s3;
	logic [SAMPLE_W-1:0] ax_s3, ay_s3;
	logic                emit_s4, ok_s4;
	logic signed [PROD_W-1:0] px_s4, py_s4;

	// rank of each sample, ties broken by position
	always_comb begin
		for (int i = 0; i < N; i++) begin
			rank_c[i] = '0;
			for (int j = 0; j < N; j++) begin
				if (j != i && (vals_s1[j] < vals_s1[i] ||
						(vals_s1[j] == vals_s1[i] && j < i))) begin
					rank_c[i] = rank_c[i] + 1'b1;
				end
			end
			keep_c[i] = rank_c[i] >= CNT_W'(LO) && rank_c[i] < CNT_W'(HI);
		end
	end

	assign stall      = emit_s4 && res_full;
	assign acc_done   = acc_busy_q && acc_cnt_q == CNT_W'(N);
	assign acc_load   = valid_s1 && (!acc_busy_q || (acc_done && !stall));
	assign s1_load    = !grp_empty && (!valid_s1 || acc_load);
	assign grp_pop    = s1_load;
	assign acc_term_c = acc_keep_q[acc_cnt_q[IDX_W-1:0]] ?
		acc_vals_q[acc_cnt_q[IDX_W-1:0]] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= 1'b1;
		end else if (acc_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			for (int i = 0; i < N; i++) begin
				vals_s1[i] <= grp_data[i*SAMPLE_W +: SAMPLE_W];
			end
			is_y_s1 <= grp_data[N*SAMPLE_W];
		end
	end

	// one sample stepped per cycle and added only when kept, the first on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_busy_q <= 1'b0;
			acc_cnt_q  <= '0;
		end else if (acc_load) begin
			acc_busy_q <= 1'b1;
			acc_cnt_q  <= CNT_W'(1);
		end else if (acc_done && !stall) begin
			acc_busy_q <= 1'b0;
		end else if (acc_busy_q && !acc_done) begin
			acc_cnt_q <= acc_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_load) begin
			acc_vals_q <= vals_s1;
			acc_keep_q <= keep_c;
			acc_is_y_q <= is_y_s1;
			acc_sum_q  <= keep_c[0] ? SUM_W'(vals_s1[0]) : '0;
		end else if (acc_busy_q && !acc_done) begin
			acc_sum_q <= acc_sum_q + SUM_W'(acc_term_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= acc_done;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			prod_s2 <= (SUM_W+RECIP_W)'(acc_sum_q) * (SUM_W+RECIP_W)'(RECIP);
			is_y_s2 <= acc_is_y_q;
		end
	end

	always_comb begin
		mean_c  = prod_s2[DIV_SH +: SAMPLE_W];
		ok_c    = held_x_q >= cfg.x_min && mean_c >= cfg.y_min;
		dx_c    = (first_x_q >= held_x_q) ? first_x_q - held_x_q : held_x_q - first_x_q;
		dy_c    = (first_y_q >= mean_c) ? first_y_q - mean_c : mean_c - first_y_q;
		agree_c = dx_c < cfg.agree_range && dy_c < cfg.agree_range;
		sum_x_c = {1'b0, first_x_q} + {1'b0, held_x_q};
		sum_y_c = {1'b0, first_y_q} + {1'b0, mean_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q  <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			second_q  <= 1'b0;
			emit_s3   <= 1'b0;
			emit_s4   <= 1'b0;
		end else if (!stall) begin
			emit_s3 <= valid_s2 && is_y_s2 && (second_q || !ok_c);
			emit_s4 <= emit_s3;
			if (valid_s2) begin
				if (!is_y_s2) begin
					held_x_q <= mean_c;
				end else if (!second_q) begin
					// first pair kept only when it shows a touch
					if (ok_c) begin
						first_x_q <= held_x_q;
						first_y_q <= mean_c;
						second_q  <= 1'b1;
					end
				end else begin
					second_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			ok_s3 <= second_q && ok_c && agree_c;
			ax_s3 <= sum_x_c[SAMPLE_W:1];
			ay_s3 <= sum_y_c[SAMPLE_W:1];
			ok_s4 <= ok_s3;
			px_s4 <= cfg.x_gain * $signed({1'b0, ax_s3});
			py_s4 <= cfg.y_gain * $signed({1'b0, ay_s3});
		end
	end

	assign res_push = emit_s4 && !res_full;

	always_comb begin
		res_data.touch_ok = ok_s4;
		res_data.x_pos    = ok_s4 ? map_axis(px_s4, cfg.x_offset) : 16'd0;
		res_data.y_pos    = ok_s4 ? map_axis(py_s4, cfg.y_offset) : 16'd0;
	end

endmodule

`default_nettype wire

>>> rtl/core/touch_sample_filter_calibrate.sv
// ----------------------------------------------------------------------------
// touch_sample_filter_calibrate
// Takes one converter sample per cycle while full is low; each group of N
// samples goes to the back end, whose accumulator steps one sample a cycle,
// adding only the kept ones, matching the input rate. A result passes stage 1,
// the accumulator, the reciprocal product and stages 3 and 4 in order.
// Asynchronous reset clears all control state and loads the default
// calibration and threshold registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module touch_sample_filter_calibrate #(
	parameter int SAMPLES_PER_GROUP = 5,
	parameter int DISCARD_EACH_END  = 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire tsfc_pkg::tsfc_sample_t          sample,
	output logic                                 full,
	output logic                                 empty,
	input  wire logic                            pop,
	output tsfc_pkg::tsfc_result_t               result,
	input  wire logic                            cfg_we,
	input  wire logic [tsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tsfc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsfc_pkg::*;

	localparam int GRP_W = SAMPLES_PER_GROUP * SAMPLE_W + 1;
	localparam int RES_W = $bits(tsfc_result_t);

	tsfc_cfg_t       cfg_q;
	logic            grp_push, grp_full, grp_pop, grp_empty;
	logic [GRP_W-1:0] grp_wdata, grp_rdata;
	logic            res_push, res_full;
	tsfc_result_t    res_data;
	logic [RES_W-1:0] res_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_gain      <= X_GAIN_RST;
			cfg_q.x_offset    <= X_OFFSET_RST;
			cfg_q.y_gain      <= Y_GAIN_RST;
			cfg_q.y_offset    <= Y_OFFSET_RST;
			cfg_q.x_min       <= X_MIN_RST;
			cfg_q.y_min       <= Y_MIN_RST;
			cfg_q.agree_range <= AGREE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_GAIN:      cfg_q.x_gain      <= cfg_data;
				REG_X_OFFSET:    cfg_q.x_offset    <= cfg_data;
				REG_Y_GAIN:      cfg_q.y_gain      <= cfg_data;
				REG_Y_OFFSET:    cfg_q.y_offset    <= cfg_data;
				REG_X_MIN:       cfg_q.x_min       <= cfg_data[SAMPLE_W-1:0];
				REG_Y_MIN:       cfg_q.y_min       <= cfg_data[SAMPLE_W-1:0];
				REG_AGREE_RANGE: cfg_q.agree_range <= cfg_data[SAMPLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tsfc_front #(
		.SAMPLES_PER_GROUP(SAMPLES_PER_GROUP)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.sample   (sample),
		.full     (full),
		.grp_push (grp_push),
		.grp_data (grp_wdata),
		.grp_full (grp_full)
	);

	tsfc_fifo #(
		.WIDTH(GRP_W),
		.DEPTH(GRP_DEPTH)
	) u_grp_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (grp_push),
		.wdata  (grp_wdata),
		.full   (grp_full),
		.pop    (grp_pop),
		.rdata  (grp_rdata),
		.empty  (grp_empty)
	);

	tsfc_back #(
		.SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
		.DISCARD_EACH_END (DISCARD_EACH_END)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_data  (grp_rdata),
		.grp_empty (grp_empty),
		.grp_pop   (grp_pop),
		.cfg       (cfg_q),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_full  (res_full)
	);

	tsfc_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.full   (res_full),
		.pop    (pop && !empty),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign result = tsfc_result_t'(res_rdata);

endmodule

`default_nettype wire
